### sv/rspr_pkg.sv
// Shared types, character codes and helpers for the packet receiver.
`default_nettype none

package rspr_pkg;

   // Field widths
   localparam int BYTE_W = 7;
   localparam int LEN_W  = 10;
   localparam int IDX_W  = 9;

   localparam int DEFAULT_BUFFER_DEPTH = 512;

   // Command codes of an input beat
   localparam logic CMD_RX   = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Kind codes of a result beat
   localparam logic KIND_SERIAL = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // Protocol characters
   localparam logic [BYTE_W-1:0] CH_START = 7'h24;  // '$'
   localparam logic [BYTE_W-1:0] CH_END   = 7'h23;  // '#'
   localparam logic [BYTE_W-1:0] CH_SEP   = 7'h3a;  // ':'
   localparam logic [BYTE_W-1:0] CH_ACK   = 7'h2b;  // '+'
   localparam logic [BYTE_W-1:0] CH_NAK   = 7'h2d;  // '-'

   typedef struct packed {
      logic             cmd;
      logic [7:0]       rx_byte;
      logic [IDX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic              out_kind;
      logic [BYTE_W-1:0] out_byte;
      logic              packet_ok;
      logic [LEN_W-1:0]  packet_len;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_DATA,
      PH_HIGH,
      PH_LOW
   } phase_type;

   // One queued response: up to three beats, ok and length go on the final one
   typedef struct packed {
      logic                        kind;
      logic                        rd_zero;
      logic [1:0]                  beats_m1;
      logic [2:0][BYTE_W-1:0]      bytes;
      logic                        ok;
      logic [LEN_W-1:0]            len;
   } job_type;

   // Decode one hex digit: {bad, value}
   function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 7'h61 && c <= 7'h66) begin
         r = {1'b0, 4'(c - 7'h57)};
      end else if (c >= 7'h30 && c <= 7'h39) begin
         r = {1'b0, 4'(c - 7'h30)};
      end else if (c >= 7'h41 && c <= 7'h46) begin
         r = {1'b0, 4'(c - 7'h37)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/rspr_beat_seq.sv
// Response sequencer: holds one queued response and feeds its beats to the output register.
`default_nettype none

module rspr_beat_seq (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            job_load,
   input  wire rspr_pkg::job_type               job_data,
   input  wire logic [rspr_pkg::BYTE_W-1:0]     rdata,
   output logic                                 job_ready,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output rspr_pkg::rsp_type                    rsp_data
);

   logic               job_valid_ff, job_valid_in;
   rspr_pkg::job_type  job_ff, job_in;
   logic [1:0]         beat_ff, beat_in;
   logic               out_valid_ff, out_valid_in;
   rspr_pkg::rsp_type  out_ff, out_in;

   logic               move;
   logic               final_beat;
   logic [rspr_pkg::BYTE_W-1:0] beat_byte;

   // Advance a beat whenever the output register is free or draining
   assign move       = job_valid_ff && (!out_valid_ff || rsp_ready);
   assign final_beat = (beat_ff == job_ff.beats_m1);
   assign job_ready  = !job_valid_ff || (move && final_beat);

   // Pick the byte of the current beat
   always_comb begin
      beat_byte = job_ff.bytes[0];
      if (job_ff.kind == rspr_pkg::KIND_READ) begin
         beat_byte = job_ff.rd_zero ? '0 : rdata;
      end else begin
         unique case (beat_ff)
            2'd0:    beat_byte = job_ff.bytes[0];
            2'd1:    beat_byte = job_ff.bytes[1];
            default: beat_byte = job_ff.bytes[2];
         endcase
      end
   end

   // Next job, beat and output register values
   always_comb begin
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      beat_in      = beat_ff;
      if (move) begin
         beat_in = final_beat ? 2'd0 : beat_ff + 2'd1;
         if (final_beat) begin
            job_valid_in = 1'b0;
         end
      end
      if (job_load) begin
         job_valid_in = 1'b1;
         job_in       = job_data;
         beat_in      = 2'd0;
      end

      out_in            = out_ff;
      out_valid_in      = out_valid_ff && !rsp_ready;
      if (move) begin
         out_valid_in       = 1'b1;
         out_in.out_kind    = job_ff.kind;
         out_in.out_byte    = beat_byte;
         out_in.packet_ok   = final_beat && job_ff.ok;
         out_in.packet_len  = final_beat ? job_ff.len : '0;
         out_in.last        = final_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         beat_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         beat_ff      <= beat_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff <= job_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

### sv/rsp_packet_receiver.sv
// Top level of the remote serial protocol packet receiver.
//
//   channel  | direction | handshake              | beat
//   ---------+-----------+------------------------+-------------------------------
//   req_     | in        | req_valid / req_ready  | req_type: cmd, rx_byte, index
//   rsp_     | out       | rsp_valid / rsp_ready  | rsp_type: kind, byte, ok, len, last
//
// One input beat per cycle is accepted while req_ready is high; a checksum close
// produces one or three result beats, paced at one per cycle by the response
// sequencer while rsp_ready is high. A read issues at acceptance into the payload
// memory (one read port) and its data is registered; its result beat, like the first
// beat of a checksum close, passes the sequencer's job and then output register.
// Reset is synchronous; the payload memory is not cleared.
// The input stalls only while a queued response still has beats to hand over.
`default_nettype none

module rsp_packet_receiver #(
   parameter int BUFFER_DEPTH = rspr_pkg::DEFAULT_BUFFER_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire rspr_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rspr_pkg::rsp_type       rsp_data
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam int PW = ((CW > rspr_pkg::IDX_W) ? CW : rspr_pkg::IDX_W) + 1;

   localparam int BW = rspr_pkg::BYTE_W;

   rspr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          high_ff, high_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                has_seq_ff, has_seq_in;
   logic [CW-1:0]       acc_len_ff, acc_len_in;
   logic [BW-1:0]       head_ff [3];
   logic [BW-1:0]       rdata_ff;
   logic [BW-1:0]       mem [BUFFER_DEPTH];

   logic                accept, is_rx, is_rd, full, store, close, match, seq_ok, hit;
   logic [BW-1:0]       ch;
   logic [4:0]          dig;
   logic [7:0]          sent;
   logic [PW-1:0]       pos;
   logic [CW-1:0]       len_now;
   logic                job_load, job_ready;
   rspr_pkg::job_type   job;

   assign accept    = req_valid && req_ready;
   assign req_ready = job_ready;
   assign ch        = req_data.rx_byte[BW-1:0];
   assign is_rx     = accept && (req_data.cmd == rspr_pkg::CMD_RX);
   assign is_rd     = accept && (req_data.cmd == rspr_pkg::CMD_READ);
   assign full      = (count_ff >= CW'(BUFFER_DEPTH));
   assign store     = is_rx && (phase_ff == rspr_pkg::PH_DATA) && (ch != rspr_pkg::CH_END) && !full;
   assign close     = is_rx && (phase_ff == rspr_pkg::PH_LOW);

   // Advance the framing phase
   always_comb begin
      phase_in = phase_ff;
      if (is_rx) begin
         unique case (phase_ff)
            rspr_pkg::PH_HUNT: begin
               if (ch == rspr_pkg::CH_START) phase_in = rspr_pkg::PH_DATA;
            end
            rspr_pkg::PH_DATA: begin
               if (ch == rspr_pkg::CH_END) phase_in = rspr_pkg::PH_HIGH;
               else if (full)              phase_in = rspr_pkg::PH_HUNT;
            end
            rspr_pkg::PH_HIGH: phase_in = rspr_pkg::PH_LOW;
            default:           phase_in = rspr_pkg::PH_HUNT;
         endcase
      end
   end

   // Checksum, length and response building
   always_comb begin
      dig     = rspr_pkg::hex_value(ch);
      sent    = high_ff + (dig[4] ? 8'hff : {4'h0, dig[3:0]});
      match   = (sent == sum_ff);
      seq_ok  = (count_ff >= CW'(3)) && (head_ff[2] == rspr_pkg::CH_SEP);
      len_now = seq_ok ? count_ff - CW'(3) : count_ff;

      pos = PW'(req_data.read_index) + (has_seq_ff ? PW'(3) : PW'(0));
      hit = (PW'(req_data.read_index) < PW'(acc_len_ff)) && (pos < PW'(BUFFER_DEPTH));

      sum_in     = sum_ff;
      count_in   = count_ff;
      high_in    = high_ff;
      has_seq_in = has_seq_ff;
      acc_len_in = acc_len_ff;
      if (is_rx && phase_ff == rspr_pkg::PH_HUNT && ch == rspr_pkg::CH_START) begin
         sum_in   = '0;
         count_in = '0;
      end
      if (store) begin
         sum_in   = sum_ff + {1'b0, ch};
         count_in = count_ff + CW'(1);
      end
      if (is_rx && phase_ff == rspr_pkg::PH_HIGH) begin
         high_in = dig[4] ? 8'hf0 : {dig[3:0], 4'h0};
      end
      if (close && match) begin
         has_seq_in = seq_ok;
         acc_len_in = len_now;
      end

      job          = '0;
      job.bytes[0] = rspr_pkg::CH_NAK;
      if (is_rd) begin
         job.kind    = rspr_pkg::KIND_READ;
         job.rd_zero = !hit;
      end else if (match) begin
         job.kind     = rspr_pkg::KIND_SERIAL;
         job.bytes[0] = rspr_pkg::CH_ACK;
         job.bytes[1] = head_ff[0];
         job.bytes[2] = head_ff[1];
         job.beats_m1 = seq_ok ? 2'd2 : 2'd0;
         job.ok       = 1'b1;
         job.len      = rspr_pkg::LEN_W'(len_now);
      end
      job_load = close || is_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rspr_pkg::PH_HUNT;
         sum_ff     <= '0;
         high_ff    <= '0;
         count_ff   <= '0;
         has_seq_ff <= 1'b0;
         acc_len_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         sum_ff     <= sum_in;
         high_ff    <= high_in;
         count_ff   <= count_in;
         has_seq_ff <= has_seq_in;
         acc_len_ff <= acc_len_in;
      end
   end

   // Keep the first three payload bytes at hand for the sequence check and echo
   always_ff @(posedge clock) begin
      if (store && count_ff == CW'(0)) head_ff[0] <= ch;
      if (store && count_ff == CW'(1)) head_ff[1] <= ch;
      if (store && count_ff == CW'(2)) head_ff[2] <= ch;
   end

   // Payload memory: write stored bytes, read on a read command
   always_ff @(posedge clock) begin
      if (store) begin
         mem[count_ff[AW-1:0]] <= ch;
      end
      if (is_rd) begin
         rdata_ff <= mem[pos[AW-1:0]];
      end
   end

   rspr_beat_seq u_beat_seq (
      .clock     (clock),
      .reset     (reset),
      .job_load  (job_load),
      .job_data  (job),
      .rdata     (rdata_ff),
      .job_ready (job_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### sv/rsp_packet_receiver_checker.sv
// Port-level checker for the packet receiver, bound to the top level.
`default_nettype none

module rsp_packet_receiver_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire rspr_pkg::req_type  req_data,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire rspr_pkg::rsp_type  rsp_data
);

   // Hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // No result beat right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat out of reset");

   // A read result is a single beat with no packet status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind == rspr_pkg::KIND_READ |->
         rsp_data.last && !rsp_data.packet_ok && rsp_data.packet_len == '0)
      else $error("malformed read result");

   // Packet status only on the final serial beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.packet_ok || rsp_data.packet_len != '0) |->
         rsp_data.last && rsp_data.out_kind == rspr_pkg::KIND_SERIAL)
      else $error("packet status on a non-final beat");

   // Hold a stalled request beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("stalled request beat changed");

endmodule

bind rsp_packet_receiver rsp_packet_receiver_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
